// ----- sv/ple_pkg.sv -----
// Shared types and codes for the positional list engine.
// Used by ple_ctrl, ple_dpath and positional_list_engine; no dependencies.
package ple_pkg;

  // Opcodes carried by an input beat
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_POS = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  // Read address select
  localparam logic [1:0] RA_POS     = 2'd0;
  localparam logic [1:0] RA_IDX_DEC = 2'd1;
  localparam logic [1:0] RA_IDX_INC = 2'd2;

  // Write address select
  localparam logic WA_POS = 1'b0;
  localparam logic WA_IDX = 1'b1;

  // Write data select
  localparam logic WD_WORD  = 1'b0;
  localparam logic WD_RDATA = 1'b1;

  // Index pointer operations
  localparam logic [2:0] IDX_HOLD     = 3'd0;
  localparam logic [2:0] IDX_LOAD_CNT = 3'd1;
  localparam logic [2:0] IDX_LOAD_POS = 3'd2;
  localparam logic [2:0] IDX_DEC      = 3'd3;
  localparam logic [2:0] IDX_INC      = 3'd4;

  // Entry count operations
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [4:0]         position;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [4:0]         item_count;
  } result_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       mem_re;
    logic [1:0] raddr_sel;
    logic       mem_we;
    logic       waddr_sel;
    logic       wdata_sel;
    logic [2:0] idx_op;
    logic [1:0] cnt_op;
    logic       finish;
    logic [1:0] fin_status;
    logic       fin_read;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic cnt_full;
    logic idx_gt_pos;
    logic idx_last;
  } sts_t;

endpackage

// ----- sv/ple_ctrl.sv -----
// Sequencing FSM of the positional list engine.
// Depends on ple_pkg for opcodes and the command/status structs.
module ple_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        opcode,
  input  ple_pkg::sts_t     sts,
  output ple_pkg::cmd_t     cmd,
  output logic              busy
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_MV_RD   = 3'd2;
  localparam logic [2:0] S_MV_WR   = 3'd3;
  localparam logic [2:0] S_RM_RD   = 3'd4;
  localparam logic [2:0] S_RM_WR   = 3'd5;
  localparam logic [2:0] S_RD_WAIT = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [2:0] op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op <= opcode;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (op)
          ple_pkg::OP_INSERT: begin
            if (sts.pos_gt_cnt) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ple_pkg::ST_BAD_POS;
              state_next     = S_IDLE;
            end else if (sts.cnt_full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ple_pkg::ST_FULL;
              state_next     = S_IDLE;
            end else begin
              cmd.idx_op = ple_pkg::IDX_LOAD_CNT;
              state_next = S_MV_RD;
            end
          end
          ple_pkg::OP_REMOVE: begin
            if (sts.pos_ge_cnt) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ple_pkg::ST_BAD_POS;
              state_next     = S_IDLE;
            end else begin
              cmd.idx_op = ple_pkg::IDX_LOAD_POS;
              state_next = S_RM_RD;
            end
          end
          ple_pkg::OP_READ: begin
            if (sts.pos_ge_cnt) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ple_pkg::ST_BAD_POS;
              state_next     = S_IDLE;
            end else begin
              cmd.mem_re    = 1'b1;
              cmd.raddr_sel = ple_pkg::RA_POS;
              state_next    = S_RD_WAIT;
            end
          end
          ple_pkg::OP_WRITE: begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
            if (sts.pos_ge_cnt) begin
              cmd.fin_status = ple_pkg::ST_BAD_POS;
            end else begin
              cmd.mem_we    = 1'b1;
              cmd.waddr_sel = ple_pkg::WA_POS;
              cmd.wdata_sel = ple_pkg::WD_WORD;
            end
          end
          ple_pkg::OP_CLEAR: begin
            cmd.cnt_op = ple_pkg::CNT_CLR;
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
          default: begin
            // unused opcodes: no effect, plain ok result
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end
        endcase
      end
      S_MV_RD: begin
        if (sts.idx_gt_pos) begin
          cmd.mem_re    = 1'b1;
          cmd.raddr_sel = ple_pkg::RA_IDX_DEC;
          state_next    = S_MV_WR;
        end else begin
          cmd.mem_we    = 1'b1;
          cmd.waddr_sel = ple_pkg::WA_POS;
          cmd.wdata_sel = ple_pkg::WD_WORD;
          cmd.cnt_op    = ple_pkg::CNT_INC;
          cmd.finish    = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_MV_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.waddr_sel = ple_pkg::WA_IDX;
        cmd.wdata_sel = ple_pkg::WD_RDATA;
        cmd.idx_op    = ple_pkg::IDX_DEC;
        state_next    = S_MV_RD;
      end
      S_RM_RD: begin
        if (!sts.idx_last) begin
          cmd.mem_re    = 1'b1;
          cmd.raddr_sel = ple_pkg::RA_IDX_INC;
          state_next    = S_RM_WR;
        end else begin
          cmd.cnt_op = ple_pkg::CNT_DEC;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RM_WR: begin
        cmd.mem_we    = 1'b1;
        cmd.waddr_sel = ple_pkg::WA_IDX;
        cmd.wdata_sel = ple_pkg::WD_RDATA;
        cmd.idx_op    = ple_pkg::IDX_INC;
        state_next    = S_RM_RD;
      end
      S_RD_WAIT: begin
        cmd.finish   = 1'b1;
        cmd.fin_read = 1'b1;
        state_next   = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/ple_dpath.sv -----
// Datapath of the positional list engine: entry memory, count, index, result register.
// Depends on ple_pkg for the payload and command/status structs.
module ple_dpath #(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  ple_pkg::item_t    item,
  input  ple_pkg::cmd_t     cmd,
  output ple_pkg::sts_t     sts,
  output ple_pkg::result_t  result,
  output logic              done
);

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > 5) ? CNT_W : 5) + 1;

  logic [WORD_WIDTH-1:0] mem [CAPACITY];

  logic [4:0]            pos;
  logic [WORD_WIDTH-1:0] word;
  logic [CNT_W-1:0]      idx;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;
  logic [WORD_WIDTH-1:0] rdata;

  logic signed [63:0]    val_ext;
  logic signed [WORD_WIDTH-1:0] rdata_s;
  logic signed [63:0]    rdata_ext;

  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      idx_ext;
  logic [CMP_W-1:0]      cnt_next_ext;
  logic [CNT_W-1:0]      idx_dec;
  logic [CNT_W-1:0]      idx_inc;
  logic [ADDR_W-1:0]     raddr;
  logic [ADDR_W-1:0]     waddr;
  logic [WORD_WIDTH-1:0] wdata;

  // Incoming value: sign-extend, keep the low WORD_WIDTH bits
  assign val_ext = 64'(item.value);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos  <= item.position;
      word <= val_ext[WORD_WIDTH-1:0];
    end
  end

  assign pos_ext      = CMP_W'(pos);
  assign cnt_ext      = CMP_W'(cnt);
  assign idx_ext      = CMP_W'(idx);
  assign cnt_next_ext = CMP_W'(cnt_next);
  assign idx_dec      = idx - CNT_W'(1);
  assign idx_inc      = idx + CNT_W'(1);

  assign sts.pos_gt_cnt = (pos_ext > cnt_ext);
  assign sts.pos_ge_cnt = (pos_ext >= cnt_ext);
  assign sts.cnt_full   = (cnt_ext == CMP_W'(CAPACITY));
  assign sts.idx_gt_pos = (idx_ext > pos_ext);
  assign sts.idx_last   = ((idx_ext + CMP_W'(1)) >= cnt_ext);

  always_ff @(posedge clk) begin
    unique case (cmd.idx_op)
      ple_pkg::IDX_LOAD_CNT: idx <= cnt;
      ple_pkg::IDX_LOAD_POS: idx <= pos_ext[CNT_W-1:0];
      ple_pkg::IDX_DEC:      idx <= idx_dec;
      ple_pkg::IDX_INC:      idx <= idx_inc;
      default:               idx <= idx;
    endcase
  end

  always_comb begin
    unique case (cmd.cnt_op)
      ple_pkg::CNT_INC: cnt_next = cnt + CNT_W'(1);
      ple_pkg::CNT_DEC: cnt_next = cnt - CNT_W'(1);
      ple_pkg::CNT_CLR: cnt_next = '0;
      default:          cnt_next = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  // Memory port addressing
  always_comb begin
    unique case (cmd.raddr_sel)
      ple_pkg::RA_IDX_DEC: raddr = idx_dec[ADDR_W-1:0];
      ple_pkg::RA_IDX_INC: raddr = idx_inc[ADDR_W-1:0];
      default:             raddr = pos_ext[ADDR_W-1:0];
    endcase
  end

  assign waddr = (cmd.waddr_sel == ple_pkg::WA_IDX) ? idx[ADDR_W-1:0] : pos_ext[ADDR_W-1:0];
  assign wdata = (cmd.wdata_sel == ple_pkg::WD_RDATA) ? rdata : word;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_re) begin
      rdata <= mem[raddr];
    end
  end

  // Read data back to 32 bits, sign-extended from WORD_WIDTH
  assign rdata_s   = rdata;
  assign rdata_ext = 64'(rdata_s);

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      result.read_value <= cmd.fin_read ? rdata_ext[31:0] : 32'sd0;
      result.status     <= cmd.fin_status;
      result.item_count <= cnt_next_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

// ----- sv/positional_list_engine.sv -----
// Top level of the positional list engine: ties controller and datapath together.
// Depends on ple_pkg, ple_ctrl and ple_dpath.
//
// Bounded ordered list of up to CAPACITY signed words kept in a single-port-write,
// registered-read memory. A command beat is taken when start is high and busy is
// low; each command yields exactly one result beat, shown on result for one cycle
// with done high. The receiver cannot stall, so the result must be taken that cycle.
// Insert and remove move the later entries one at a time through the memory: a
// read then a write per entry moved. Insert moves entries from the tail down to
// the position, then writes the new word; remove moves entries from the position
// up to the tail. Read waits on the registered memory read. Write, clear, a bad
// position, a full list and an unused opcode all end in the execute state.
// The result beat follows the last busy cycle, and a new command may be given in
// that same cycle. The memory needs no clearing after reset: only entries below
// the count are ever read, and those have all been written.
// Status: ok, bad position (insert past count, or remove/read/write at or past
// count), or full (insert at count equal to CAPACITY; position is checked first).
// read_value is zero except on a good read. item_count is the count after the
// command, low five bits.
module positional_list_engine #(
  parameter int CAPACITY   = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ple_pkg::item_t    item,
  output ple_pkg::result_t  result,
  output logic              done
);

  ple_pkg::cmd_t cmd;
  ple_pkg::sts_t sts;

  ple_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  ple_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .sts    (sts),
    .result (result),
    .done   (done)
  );

`ifndef NO_ASSERTIONS
  // A result beat lands in a cycle where the engine is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  // Each result beat is preceded by a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("result beat without a command in flight");

  // An accepted command makes the engine busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |=> busy)
    else $error("accepted command did not start");

  // Only a good read carries data
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
      (done && result.status != ple_pkg::ST_OK) |-> (result.read_value == 32'sd0))
    else $error("nonzero read_value on error status");
`endif

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for positional_list_engine: directed and random command beats.
// Depends on ple_pkg and the RTL of positional_list_engine; needs no other files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIST_DEPTH = 16;
  localparam int RANDOM_BEATS = 1250;
  // No beat taken and no result seen for this long means the block is hung.
  // The slowest command is an insert at 0 into 15 entries.
  localparam int STALL_LIMIT = 2000;
  // Quiet time after the last result before the final verdict.
  localparam int DRAIN_CYCLES = 40;
  // Opcode codes the block does not define; it must answer them with ok.
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED  = 3'd7;

  // Shadow copy of the list: applies each taken command and queues the
  // result beat it must produce.
  class list_shadow;
    logic signed [31:0] words [LIST_DEPTH];
    int                 count;
    ple_pkg::result_t   pending_results [$];
    int                 errors;
    int                 per_op [8];
    int                 full_hits;
    int                 bad_pos_hits;
    int                 shifted_entries;

    function new();
      count = 0;
      errors = 0;
      full_hits = 0;
      bad_pos_hits = 0;
      shifted_entries = 0;
      foreach (per_op[i]) per_op[i] = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    function void note_command(ple_pkg::item_t it);
      ple_pkg::result_t r;
      int               p;
      r = '0;
      r.status = ple_pkg::ST_OK;
      p = int'(it.position);
      per_op[it.opcode]++;
      case (it.opcode)
        ple_pkg::OP_INSERT: begin
          // position is checked before fullness
          if (p > count) begin
            r.status = ple_pkg::ST_BAD_POS;
          end else if (count >= LIST_DEPTH) begin
            r.status = ple_pkg::ST_FULL;
          end else begin
            for (int i = count; i > p; i--) words[i] = words[i-1];
            words[p] = it.value;
            shifted_entries += count - p;
            count++;
          end
        end
        ple_pkg::OP_REMOVE: begin
          if (p >= count) begin
            r.status = ple_pkg::ST_BAD_POS;
          end else begin
            for (int i = p; i + 1 < count; i++) words[i] = words[i+1];
            shifted_entries += count - p - 1;
            count--;
          end
        end
        ple_pkg::OP_READ: begin
          if (p >= count) r.status = ple_pkg::ST_BAD_POS;
          else r.read_value = words[p];
        end
        ple_pkg::OP_WRITE: begin
          if (p >= count) r.status = ple_pkg::ST_BAD_POS;
          else words[p] = it.value;
        end
        ple_pkg::OP_CLEAR: count = 0;
        default: ;
      endcase
      if (r.status == ple_pkg::ST_FULL) full_hits++;
      if (r.status == ple_pkg::ST_BAD_POS) bad_pos_hits++;
      r.item_count = 5'(count);
      pending_results.push_back(r);
    endfunction

    function void check_result(ple_pkg::result_t got);
      ple_pkg::result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected: actual %p", $time, got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (got.read_value !== want.read_value) begin
        $display("%0t: read_value mismatch: expected %h actual %h",
                 $time, want.read_value, got.read_value);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.item_count !== want.item_count) begin
        $display("%0t: item_count mismatch: expected %0d actual %0d",
                 $time, want.item_count, got.item_count);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst;
  logic             start;
  logic             busy;
  ple_pkg::item_t   item;
  ple_pkg::result_t result;
  logic             done;

  list_shadow board = new();
  int         stall_cycles = 0;
  int         beats_sent = 0;

  positional_list_engine #(
    .CAPACITY   (LIST_DEPTH),
    .WORD_WIDTH (32)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .result (result),
    .done   (done)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: done marks a one-cycle beat that the receiver must take.
  // Sampled at the edge that ends the cycle, before the block's own updates.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // Watchdog: resets on every taken command beat and every result beat.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $time, STALL_LIMIT, board.pending_results.size());
        $display("positional_list_engine regression: fail");
        $finish;
      end
    end
  end

  // Present one command beat and hold it until busy is low at an edge.
  // Called at a rising edge; returns at the edge that took the beat.
  task automatic send_command(ple_pkg::item_t it);
    start <= 1'b1;
    item  <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_command(it);
    beats_sent++;
  endtask

  // Random gap after a beat (about 7 in 100 beats): start is dropped while the bench idles.
  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  function automatic ple_pkg::item_t make_item(logic [2:0] op, int pos,
                                               logic signed [31:0] val);
    ple_pkg::item_t it;
    it.opcode   = op;
    it.position = 5'(pos);
    it.value    = val;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 19))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Random command mostly aimed at legal positions so the list fills and
  // drains; the rest stray outside the list or use unused opcodes.
  function automatic ple_pkg::item_t pick_command(int cnt);
    logic [2:0] op;
    int         pos;
    int         roll;
    roll = $urandom_range(0, 99);
    // lean toward inserts when nearly empty and removes when nearly full
    if (cnt < 4 && roll < 20) roll = 0;
    if (cnt > 13 && roll < 20) roll = 40;
    if (roll < 34)      op = ple_pkg::OP_INSERT;
    else if (roll < 54) op = ple_pkg::OP_REMOVE;
    else if (roll < 78) op = ple_pkg::OP_READ;
    else if (roll < 94) op = ple_pkg::OP_WRITE;
    else if (roll < 97) op = ple_pkg::OP_CLEAR;
    else                op = 3'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    if ($urandom_range(0, 99) < 12) begin
      pos = $urandom_range(0, 31);
    end else if (op == ple_pkg::OP_INSERT) begin
      pos = $urandom_range(0, cnt);
    end else if (cnt > 0) begin
      pos = $urandom_range(0, cnt - 1);
    end else begin
      pos = $urandom_range(0, 3);
    end
    return make_item(op, pos, pick_value());
  endfunction

  initial begin
    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list corner cases first.
    send_command(make_item(ple_pkg::OP_CLEAR,  0, '0));
    send_command(make_item(ple_pkg::OP_READ,   0, '0));
    send_command(make_item(ple_pkg::OP_REMOVE, 0, '0));
    send_command(make_item(ple_pkg::OP_WRITE,  0, 32'sd5));
    send_command(make_item(ple_pkg::OP_INSERT, 1, 32'sd9));     // past count on empty list
    send_command(make_item(ple_pkg::OP_INSERT, 0, 32'sh7fff_ffff));
    send_command(make_item(ple_pkg::OP_INSERT, 1, 32'sh8000_0000));
    send_command(make_item(ple_pkg::OP_INSERT, 1, -32'sd1));    // middle insert shifts one
    // Fill to capacity, always at the head so every insert moves the whole list.
    for (int i = 3; i < LIST_DEPTH; i++)
      send_command(make_item(ple_pkg::OP_INSERT, 0, 32'(i * 32'h0101_0101)));
    send_command(make_item(ple_pkg::OP_INSERT, LIST_DEPTH, 32'sd1));      // full list
    send_command(make_item(ple_pkg::OP_INSERT, LIST_DEPTH + 1, 32'sd1));  // position wins
    send_command(make_item(ple_pkg::OP_INSERT, 31, 32'sd1));
    send_command(make_item(ple_pkg::OP_READ,   0, '0));
    send_command(make_item(ple_pkg::OP_READ,   LIST_DEPTH - 1, '0));
    send_command(make_item(ple_pkg::OP_READ,   LIST_DEPTH, '0));
    send_command(make_item(ple_pkg::OP_WRITE,  LIST_DEPTH - 1, -32'sd1));
    send_command(make_item(ple_pkg::OP_READ,   LIST_DEPTH - 1, '0));
    send_command(make_item(ple_pkg::OP_REMOVE, 0, '0));         // longest remove
    send_command(make_item(ple_pkg::OP_REMOVE, LIST_DEPTH - 2, '0));  // last entry, no shift
    send_command(make_item(ple_pkg::OP_REMOVE, LIST_DEPTH, '0));
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
      send_command(make_item(3'(op), 2, 32'sh5a5a_a5a5));
    send_command(make_item(ple_pkg::OP_CLEAR,  7, 32'sd3));
    send_command(make_item(ple_pkg::OP_READ,   0, '0));

    // Random phase; beats 400 to 700 run back to back with no gaps.
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      send_command(pick_command(board.count));
      maybe_idle(n >= 400 && n < 700);
    end
    start <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d beats: %0d insert, %0d remove, %0d read, %0d write, %0d clear",
             beats_sent, board.per_op[ple_pkg::OP_INSERT], board.per_op[ple_pkg::OP_REMOVE],
             board.per_op[ple_pkg::OP_READ], board.per_op[ple_pkg::OP_WRITE],
             board.per_op[ple_pkg::OP_CLEAR]);
    $display("  %0d full, %0d bad position, %0d entries shifted, %0d mismatches",
             board.full_hits, board.bad_pos_hits, board.shifted_entries, board.errors);
    if (board.errors == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ple_pkg.sv
sv/ple_ctrl.sv
sv/ple_dpath.sv
sv/positional_list_engine.sv
verif/testbench.sv
